@@ rtl/core/iqfs_pkg.sv @@
// ----------------------------------------------------------------------------
// iqfs_pkg
// Shared types and codes of the interrupt queue and frame stack unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iqfs_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_TABLE_BASE   = 2'd0;
   localparam logic [1:0] CSR_TABLE_LENGTH = 2'd1;
   localparam logic [1:0] CSR_MEMORY_SIZE  = 2'd2;

   // Size of one vector table entry, as a shift
   localparam int ENTRY_SHIFT = 3;
   localparam logic [63:0] ENTRY_BYTES = 64'd8;

   // Command of one request beat
   typedef enum logic [1:0] {
      CMD_RAISE    = 2'd0,
      CMD_DISPATCH = 2'd1,
      CMD_HANDLER  = 2'd2,
      CMD_RETURN   = 2'd3
   } cmd_type;

   // Result status codes
   typedef enum logic [3:0] {
      STAT_OK            = 4'd0,
      STAT_QUEUE_FULL    = 4'd1,
      STAT_TABLE_UNSET   = 4'd2,
      STAT_VECTOR_RANGE  = 4'd3,
      STAT_TABLE_BIG     = 4'd4,
      STAT_TABLE_OUTSIDE = 4'd5,
      STAT_SLOT_OUTSIDE  = 4'd6,
      STAT_NULL_HANDLER  = 4'd7,
      STAT_NEST_OVERFLOW = 4'd8,
      STAT_NO_FRAME      = 4'd9
   } status_type;

   // Result action codes
   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_FETCH   = 2'd1,
      ACT_ENTER   = 2'd2,
      ACT_RESTORE = 2'd3
   } action_type;

   // Outcome of the vector table check
   typedef struct packed {
      status_type  status;
      logic [63:0] address;
   } check_type;

endpackage

`default_nettype wire

@@ rtl/core/iqfs_ram.sv @@
// ----------------------------------------------------------------------------
// iqfs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module iqfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/iqfs_vec_check.sv @@
// ----------------------------------------------------------------------------
// iqfs_vec_check
// Vector table registers and bound checks of a dispatched vector.
// ----------------------------------------------------------------------------
`default_nettype none

module iqfs_vec_check (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [63:0]       csr_write_data,
   input  wire logic [7:0]        vid,
   output iqfs_pkg::check_type    chk
);

   logic [63:0] table_base_ff;
   logic [31:0] table_length_ff;
   logic [63:0] memory_size_ff;

   // per-table terms, registered from the configuration registers
   logic        unset_ff,   unset_in;
   logic        too_big_ff, too_big_in;
   logic        outside_ff, outside_in;
   logic [63:0] end_ff,     end_in;

   logic [63:0] entry;
   logic [63:0] entry_end;
   logic        range_bad;
   logic        slot_bad;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff   <= '0;
         table_length_ff <= '0;
         memory_size_ff  <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            iqfs_pkg::CSR_TABLE_BASE:   table_base_ff   <= csr_write_data;
            iqfs_pkg::CSR_TABLE_LENGTH: table_length_ff <= csr_write_data[31:0];
            iqfs_pkg::CSR_MEMORY_SIZE:  memory_size_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // table-wide checks, independent of the vector
   always_comb begin
      unset_in   = (table_length_ff == 32'd0);
      too_big_in = ({32'd0, table_length_ff} > (memory_size_ff >> iqfs_pkg::ENTRY_SHIFT));
      end_in     = table_base_ff +
                   ({32'd0, table_length_ff} << iqfs_pkg::ENTRY_SHIFT);
      outside_in = (end_in > memory_size_ff) || (end_in < table_base_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unset_ff   <= 1'b1;
         too_big_ff <= 1'b0;
         outside_ff <= 1'b0;
         end_ff     <= '0;
      end else begin
         unset_ff   <= unset_in;
         too_big_ff <= too_big_in;
         outside_ff <= outside_in;
         end_ff     <= end_in;
      end
   end

   // per-vector checks, 64-bit wrapping sums
   always_comb begin
      entry     = table_base_ff + {53'd0, vid, 3'd0};
      entry_end = entry + iqfs_pkg::ENTRY_BYTES;
      range_bad = ({24'd0, vid} >= table_length_ff);
      slot_bad  = (entry_end > memory_size_ff) || (entry_end > end_ff) ||
                  (entry < table_base_ff);
      chk.address = entry;
      if (unset_ff) begin
         chk.status = iqfs_pkg::STAT_TABLE_UNSET;
      end else if (range_bad) begin
         chk.status = iqfs_pkg::STAT_VECTOR_RANGE;
      end else if (too_big_ff) begin
         chk.status = iqfs_pkg::STAT_TABLE_BIG;
      end else if (outside_ff) begin
         chk.status = iqfs_pkg::STAT_TABLE_OUTSIDE;
      end else if (slot_bad) begin
         chk.status = iqfs_pkg::STAT_SLOT_OUTSIDE;
      end else begin
         chk.status = iqfs_pkg::STAT_OK;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/interrupt_queue_and_frame_stack_unit.sv @@
// ----------------------------------------------------------------------------
// interrupt_queue_and_frame_stack_unit
// Pending vector queue and nested interrupt frame stack of a core.
//
// Request channel (req_valid / req_stall) carries one command per beat:
// raise a vector, try a dispatch, hand back a fetched table word, or return
// from an interrupt. Every request beat gives exactly one response beat on
// rsp_valid / rsp_stall, in order.
// The response is registered in the output slot when the request is executed.
// A new request is taken only once the last one is executed; the pending
// queue and the frame stack sit in RAMs with registered read data, read when
// a request is accepted and written back when it is executed.
// A result that waits on a stalled receiver does not block the next request:
// it is taken and read, and only its write-back waits for the output slot.
// Table registers go through csr_write_enable / csr_index / csr_write_data.
// The user must write them while no request is in flight; it is not enforced.
// Reset (synchronous) empties the queue and the stack, clears the delivery
// count and the table registers. Queue and stack RAMs are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module interrupt_queue_and_frame_stack_unit #(
   parameter int QUEUE_DEPTH  = 64,
   parameter int NEST_LIMIT   = 3,
   parameter int INT_FLAG_BIT = 9
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [7:0]  req_vector,
   input  wire logic        req_halted,
   input  wire logic [63:0] req_current_ic,
   input  wire logic [63:0] req_current_flags,
   input  wire logic [63:0] req_handler_word,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [3:0]       rsp_status,
   output logic [1:0]       rsp_action,
   output logic [63:0]      rsp_fetch_address,
   output logic [63:0]      rsp_new_ic,
   output logic [63:0]      rsp_new_flags,
   output logic [63:0]      rsp_delivered_count,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_write_data
);

   localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);
   localparam int SAW = (NEST_LIMIT > 1) ? $clog2(NEST_LIMIT) : 1;
   localparam int NDW = $clog2(NEST_LIMIT + 1);
   localparam logic [QAW-1:0] QLAST    = QAW'(QUEUE_DEPTH - 1);
   localparam logic [QCW-1:0] QFULL    = QCW'(QUEUE_DEPTH);
   localparam logic [NDW-1:0] NFULL    = NDW'(NEST_LIMIT);
   localparam logic [63:0]    INT_MASK = 64'd1 << INT_FLAG_BIT;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;

   // queue and stack control
   logic [QAW-1:0]  head_ff,    head_in;
   logic [QAW-1:0]  tail_ff,    tail_in;
   logic [QCW-1:0]  count_ff,   count_in;
   logic [NDW-1:0]  nest_ff,    nest_in;
   logic [NDW-1:0]  nest_dec;
   logic [63:0]     deliv_ff,   deliv_in;
   logic            await_ff,   await_in;

   // captured request beat
   iqfs_pkg::cmd_type item_cmd_ff;
   logic [7:0]      item_vector_ff;
   logic            item_halted_ff;
   logic [63:0]     item_ic_ff;
   logic [63:0]     item_flags_ff;
   logic [63:0]     item_handler_ff;

   // output slot
   logic            rsp_valid_ff, rsp_valid_in;
   iqfs_pkg::status_type status_ff, status_in;
   iqfs_pkg::action_type action_ff, action_in;
   logic [63:0]     fetch_ff,   fetch_in;
   logic [63:0]     nic_ff,     nic_in;
   logic [63:0]     nflags_ff,  nflags_in;
   logic [63:0]     count_out_ff;

   logic            accept;
   logic            commit;
   logic            fifo_we;
   logic            stack_we;
   logic [7:0]      fifo_rd;
   logic [127:0]    stack_rd;
   iqfs_pkg::check_type chk;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign commit    = (state_ff == ST_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = (state_ff != ST_IDLE);
   assign nest_dec  = nest_ff - NDW'(1);

   // pending vector queue
   iqfs_ram #(
      .WIDTH (8),
      .DEPTH (QUEUE_DEPTH),
      .AW    (QAW)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (item_vector_ff),
      .rd_en   (accept),
      .rd_addr (head_ff),
      .rd_data (fifo_rd)
   );

   // saved frames: instruction counter in the upper half, flags below
   iqfs_ram #(
      .WIDTH (128),
      .DEPTH (NEST_LIMIT),
      .AW    (SAW)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (nest_ff[SAW-1:0]),
      .wr_data ({item_ic_ff, item_flags_ff}),
      .rd_en   (accept),
      .rd_addr (nest_dec[SAW-1:0]),
      .rd_data (stack_rd)
   );

   iqfs_vec_check u_vec_check (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .vid              (fifo_rd),
      .chk              (chk)
   );

   // command execution, applied when the output slot is free
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      nest_in   = nest_ff;
      deliv_in  = deliv_ff;
      await_in  = await_ff;
      fifo_we   = 1'b0;
      stack_we  = 1'b0;
      status_in = iqfs_pkg::STAT_OK;
      action_in = iqfs_pkg::ACT_NONE;
      fetch_in  = '0;
      nic_in    = '0;
      nflags_in = '0;

      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase

      if (commit) begin
         case (item_cmd_ff)
            iqfs_pkg::CMD_RAISE: begin
               if (count_ff == QFULL) begin
                  status_in = iqfs_pkg::STAT_QUEUE_FULL;
               end else begin
                  fifo_we  = 1'b1;
                  tail_in  = (tail_ff == QLAST) ? '0 : tail_ff + QAW'(1);
                  count_in = count_ff + QCW'(1);
               end
            end
            iqfs_pkg::CMD_DISPATCH: begin
               if (!item_halted_ff && (count_ff != '0) &&
                   ((item_flags_ff & INT_MASK) != '0) && !await_ff) begin
                  head_in   = (head_ff == QLAST) ? '0 : head_ff + QAW'(1);
                  count_in  = count_ff - QCW'(1);
                  status_in = chk.status;
                  if (chk.status == iqfs_pkg::STAT_OK) begin
                     action_in = iqfs_pkg::ACT_FETCH;
                     fetch_in  = chk.address;
                     await_in  = 1'b1;
                  end
               end
            end
            iqfs_pkg::CMD_HANDLER: begin
               if (await_ff) begin
                  await_in = 1'b0;
                  if (item_handler_ff == '0) begin
                     status_in = iqfs_pkg::STAT_NULL_HANDLER;
                  end else if (nest_ff >= NFULL) begin
                     status_in = iqfs_pkg::STAT_NEST_OVERFLOW;
                  end else begin
                     stack_we  = 1'b1;
                     nest_in   = nest_ff + NDW'(1);
                     action_in = iqfs_pkg::ACT_ENTER;
                     nic_in    = item_handler_ff;
                     nflags_in = item_flags_ff & ~INT_MASK;
                     deliv_in  = deliv_ff + 64'd1;
                  end
               end
            end
            default: begin
               // interrupt return
               if (nest_ff == '0) begin
                  status_in = iqfs_pkg::STAT_NO_FRAME;
               end else begin
                  nest_in   = nest_dec;
                  action_in = iqfs_pkg::ACT_RESTORE;
                  nic_in    = stack_rd[127:64];
                  nflags_in = stack_rd[63:0];
               end
            end
         endcase
      end

      rsp_valid_in = commit || (rsp_valid_ff && rsp_stall);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         nest_ff      <= '0;
         deliv_ff     <= '0;
         await_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         nest_ff      <= nest_in;
         deliv_ff     <= deliv_in;
         await_ff     <= await_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         item_cmd_ff     <= iqfs_pkg::cmd_type'(req_cmd);
         item_vector_ff  <= req_vector;
         item_halted_ff  <= req_halted;
         item_ic_ff      <= req_current_ic;
         item_flags_ff   <= req_current_flags;
         item_handler_ff <= req_handler_word;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff    <= status_in;
         action_ff    <= action_in;
         fetch_ff     <= fetch_in;
         nic_ff       <= nic_in;
         nflags_ff    <= nflags_in;
         count_out_ff <= deliv_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = status_ff;
   assign rsp_action          = action_ff;
   assign rsp_fetch_address   = fetch_ff;
   assign rsp_new_ic          = nic_ff;
   assign rsp_new_flags       = nflags_ff;
   assign rsp_delivered_count = count_out_ff;

endmodule

`default_nettype wire
